// File: design/sacs_pkg.sv
// Shared types and constants for the stick average / calibrate / scale block.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none

package sacs_pkg;

  // Fixed field widths
  localparam int NUM_CH     = 4;
  localparam int CH_W       = 2;
  localparam int SMP_W      = 12;
  localparam int AVG_W      = 20;
  localparam int CSUM_W     = 32;
  localparam int CNT_W      = 11;
  localparam int WLEN_W     = 5;
  localparam int PROD_W     = 34;
  localparam int FRAC_SH    = 8;
  localparam int GAIN_SH    = 20;

  // Shared divider
  localparam int DIV_W      = 32;
  localparam int DVS_W      = 11;
  localparam int NB_W       = 6;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_COUNT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_VALUE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT  = 3'd5;

  // Register reset values
  localparam logic [WLEN_W-1:0] RST_WINDOW_LEN   = 5'd10;
  localparam logic [CNT_W-1:0]  RST_CAL_COUNT    = 11'd100;
  localparam logic [SMP_W-1:0]  RST_GAIN         = 12'd990;
  localparam logic [SMP_W-1:0]  RST_CENTER_VALUE = 12'd1500;
  localparam logic [SMP_W-1:0]  RST_UPPER_LIMIT  = 12'd1999;
  localparam logic [SMP_W-1:0]  RST_LOWER_LIMIT  = 12'd1001;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_AVG_DIV,
    ST_MUL,
    ST_CLAMP,
    ST_CAL_ACC,
    ST_CAL_START,
    ST_CAL_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [NB_W-1:0]  nbits;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: design/sacs_in_if.sv
// Input channel: one word of four raw stick samples plus the op bit.
// Depends on sacs_pkg for the sample width.
`default_nettype none

interface sacs_in_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [sacs_pkg::SMP_W-1:0] left_x;
  logic [sacs_pkg::SMP_W-1:0] left_y;
  logic [sacs_pkg::SMP_W-1:0] right_x;
  logic [sacs_pkg::SMP_W-1:0] right_y;

  modport source (output valid, op, left_x, left_y, right_x, right_y, input ready);
  modport sink   (input valid, op, left_x, left_y, right_x, right_y, output ready);
endinterface

`default_nettype wire

// File: design/sacs_out_if.sv
// Result channel: one word of four throttles plus calibration status.
// Depends on sacs_pkg for the throttle width.
`default_nettype none

interface sacs_out_if;
  logic                       valid;
  logic                       ready;
  logic [sacs_pkg::SMP_W-1:0] yaw_out;
  logic [sacs_pkg::SMP_W-1:0] height_out;
  logic [sacs_pkg::SMP_W-1:0] pitch_out;
  logic [sacs_pkg::SMP_W-1:0] roll_out;
  logic                       calibrated;
  logic                       cal_done;

  modport source (output valid, yaw_out, height_out, pitch_out, roll_out, calibrated,
                  cal_done, input ready);
  modport sink   (input valid, yaw_out, height_out, pitch_out, roll_out, calibrated,
                  cal_done, output ready);
endinterface

`default_nettype wire

// File: design/stick_average_calibrate_scale_top.sv
// Stick average / calibrate / scale: top level with window memory and sequencer.
// Depends on sacs_pkg, sacs_in_if, sacs_out_if and sacs_div.
`default_nettype none

// Each accepted word carries four 12-bit stick samples (left_x, left_y,
// right_x, right_y). Every channel runs a moving average over the last
// window_len samples (0, or anything above MAX_WINDOW, selects MAX_WINDOW);
// the window starts as zeros and is cleared whenever window_len is written.
// The average is kept in Q8 counts. After reset, or on a word with op set,
// the block calibrates: the averages of cal_count words are averaged into
// per-channel offsets, and the word that finishes reports cal_done. From the
// next word on, throttles are center_value + trunc0((avg - offset) * gain
// / 2^20), clamped to upper_limit and then lower_limit; before that they
// report center_value. One word is processed at a time. The window samples
// live in a single-port-read synchronous memory of 4*MAX_WINDOW entries;
// each channel takes a read, a read-modify-write of its running sum and one
// pass through the shared radix-2 divider, which sets the rate. The word that
// completes calibration adds four offset divisions, one per channel. A result
// that waits for the sink adds its stall. The result sits in an output
// register, so a new word is taken while the last result waits. Configuration
// writes are taken any cycle but are meant for an idle block.
module stick_average_calibrate_scale_top #(
  parameter int MAX_WINDOW = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [sacs_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  wire logic [sacs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  sacs_in_if.sink                                  in_chan,
  sacs_out_if.source                               out_chan
);

  localparam int SLOT_W   = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W    = sacs_pkg::SMP_W + SLOT_W;
  localparam int AVG_BITS = SUM_W + sacs_pkg::FRAC_SH;
  localparam int DEPTH    = sacs_pkg::NUM_CH * MAX_WINDOW;
  localparam int AW       = $clog2(DEPTH);

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  logic [sacs_pkg::WLEN_W-1:0] win_len_r;
  logic [sacs_pkg::CNT_W-1:0]  cal_cnt_r;
  logic [sacs_pkg::SMP_W-1:0]  gain_r;
  logic [sacs_pkg::SMP_W-1:0]  center_r;
  logic [sacs_pkg::SMP_W-1:0]  upper_r;
  logic [sacs_pkg::SMP_W-1:0]  lower_r;
  logic                        win_clr;

  assign win_clr = cfg_we && (cfg_idx == sacs_pkg::REG_WINDOW_LEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= sacs_pkg::RST_WINDOW_LEN;
      cal_cnt_r <= sacs_pkg::RST_CAL_COUNT;
      gain_r    <= sacs_pkg::RST_GAIN;
      center_r  <= sacs_pkg::RST_CENTER_VALUE;
      upper_r   <= sacs_pkg::RST_UPPER_LIMIT;
      lower_r   <= sacs_pkg::RST_LOWER_LIMIT;
    end else if (cfg_we) begin
      case (cfg_idx)
        sacs_pkg::REG_WINDOW_LEN:   win_len_r <= cfg_wdata[sacs_pkg::WLEN_W-1:0];
        sacs_pkg::REG_CAL_COUNT:    cal_cnt_r <= cfg_wdata[sacs_pkg::CNT_W-1:0];
        sacs_pkg::REG_GAIN:         gain_r    <= cfg_wdata;
        sacs_pkg::REG_CENTER_VALUE: center_r  <= cfg_wdata;
        sacs_pkg::REG_UPPER_LIMIT:  upper_r   <= cfg_wdata;
        sacs_pkg::REG_LOWER_LIMIT:  lower_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective window length: zero or oversize selects the full window
  logic [SLOT_W-1:0] w_eff;
  assign w_eff = (win_len_r == '0 || int'(win_len_r) > MAX_WINDOW)
                 ? SLOT_W'(MAX_WINDOW) : SLOT_W'(win_len_r);

  // ------------------------------------------------------------------
  // Sequencer state and per-word registers
  // ------------------------------------------------------------------
  sacs_pkg::state_t state_r, state_nxt;

  logic [sacs_pkg::CH_W-1:0]  ch_r;
  logic [SLOT_W-1:0]          slot_r;
  logic [SLOT_W-1:0]          write_slot_r;
  logic [SLOT_W-1:0]          slot_eff;
  logic [sacs_pkg::SMP_W-1:0] smp_r   [sacs_pkg::NUM_CH];
  logic [sacs_pkg::AVG_W-1:0] avg_r   [sacs_pkg::NUM_CH];
  logic [sacs_pkg::SMP_W-1:0] thr_r   [sacs_pkg::NUM_CH];
  logic [SUM_W-1:0]           wsum_r  [sacs_pkg::NUM_CH];
  logic                       was_cal_r;
  logic                       done_r;
  logic signed [sacs_pkg::PROD_W-1:0] prod_r;

  // Calibration state
  logic [sacs_pkg::CSUM_W-1:0] cal_sum_r [sacs_pkg::NUM_CH];
  logic [sacs_pkg::AVG_W-1:0]  offs_r    [sacs_pkg::NUM_CH];
  logic [sacs_pkg::CNT_W-1:0]  cal_ctr_r;
  logic                        is_cal_r;

  // Window memory and its valid bits (cleared at reset and on a length write)
  logic [sacs_pkg::SMP_W-1:0] win_mem [DEPTH];
  logic [sacs_pkg::SMP_W-1:0] win_rd_r;
  logic [DEPTH-1:0]           win_vld_r;
  logic                       rd_vld_r;
  logic [AW-1:0]              mem_addr;

  // Output register
  logic                       out_valid_r;
  logic [sacs_pkg::SMP_W-1:0] out_yaw_r;
  logic [sacs_pkg::SMP_W-1:0] out_height_r;
  logic [sacs_pkg::SMP_W-1:0] out_pitch_r;
  logic [sacs_pkg::SMP_W-1:0] out_roll_r;
  logic                       out_calibrated_r;
  logic                       out_cal_done_r;

  // Control from the sequencer
  logic in_ready;
  logic in_acc;
  logic mem_re;
  logic mem_we;
  logic div_start;
  logic div_sel_cal;
  logic ch_inc;
  logic ch_clr;
  logic avg_cap;
  logic mul_en;
  logic thr_cap;
  logic cal_acc;
  logic off_cap;
  logic cal_fin;
  logic load_out;
  logic out_free;

  logic last_ch;
  logic cal_complete;
  logic [sacs_pkg::CNT_W-1:0] cal_need;
  logic [sacs_pkg::CNT_W-1:0] ctr_inc;

  sacs_pkg::div_req_t div_req;
  sacs_pkg::div_rsp_t div_rsp;

  assign in_acc   = in_chan.valid && in_ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign last_ch  = ch_r == sacs_pkg::CH_W'(sacs_pkg::NUM_CH - 1);
  assign slot_eff = (write_slot_r >= w_eff) ? '0 : write_slot_r;
  assign mem_addr = AW'(int'(ch_r) * MAX_WINDOW + int'(slot_r));

  assign cal_need     = (cal_cnt_r == '0) ? sacs_pkg::CNT_W'(1) : cal_cnt_r;
  assign ctr_inc      = cal_ctr_r + sacs_pkg::CNT_W'(1);
  assign cal_complete = ctr_inc >= cal_need;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sacs_pkg::ST_IDLE:      if (in_acc) state_nxt = sacs_pkg::ST_READ;
      sacs_pkg::ST_READ:      state_nxt = sacs_pkg::ST_UPDATE;
      sacs_pkg::ST_UPDATE:    state_nxt = sacs_pkg::ST_AVG_DIV;
      sacs_pkg::ST_AVG_DIV: begin
        if (div_rsp.done) begin
          if (!last_ch)       state_nxt = sacs_pkg::ST_READ;
          else if (was_cal_r) state_nxt = sacs_pkg::ST_MUL;
          else                state_nxt = sacs_pkg::ST_CAL_ACC;
        end
      end
      sacs_pkg::ST_MUL:       state_nxt = sacs_pkg::ST_CLAMP;
      sacs_pkg::ST_CLAMP:     state_nxt = last_ch ? sacs_pkg::ST_OUT : sacs_pkg::ST_MUL;
      sacs_pkg::ST_CAL_ACC:   state_nxt = cal_complete ? sacs_pkg::ST_CAL_START
                                                       : sacs_pkg::ST_OUT;
      sacs_pkg::ST_CAL_START: state_nxt = sacs_pkg::ST_CAL_DIV;
      sacs_pkg::ST_CAL_DIV: begin
        if (div_rsp.done) begin
          state_nxt = last_ch ? sacs_pkg::ST_OUT : sacs_pkg::ST_CAL_START;
        end
      end
      sacs_pkg::ST_OUT:       if (out_free) state_nxt = sacs_pkg::ST_IDLE;
      default:                state_nxt = sacs_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready    = 1'b0;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    div_start   = 1'b0;
    div_sel_cal = 1'b0;
    ch_inc      = 1'b0;
    ch_clr      = 1'b0;
    avg_cap     = 1'b0;
    mul_en      = 1'b0;
    thr_cap     = 1'b0;
    cal_acc     = 1'b0;
    off_cap     = 1'b0;
    cal_fin     = 1'b0;
    load_out    = 1'b0;
    case (state_r)
      sacs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        ch_clr   = 1'b1;
      end
      sacs_pkg::ST_READ:   mem_re = 1'b1;
      sacs_pkg::ST_UPDATE: begin
        mem_we    = 1'b1;
        div_start = 1'b1;
      end
      sacs_pkg::ST_AVG_DIV: begin
        if (div_rsp.done) begin
          avg_cap = 1'b1;
          ch_inc  = !last_ch;
          ch_clr  = last_ch;
        end
      end
      sacs_pkg::ST_MUL:   mul_en = 1'b1;
      sacs_pkg::ST_CLAMP: begin
        thr_cap = 1'b1;
        ch_inc  = !last_ch;
      end
      sacs_pkg::ST_CAL_ACC: begin
        cal_acc = 1'b1;
        ch_clr  = 1'b1;
      end
      sacs_pkg::ST_CAL_START: begin
        div_start   = 1'b1;
        div_sel_cal = 1'b1;
      end
      sacs_pkg::ST_CAL_DIV: begin
        if (div_rsp.done) begin
          off_cap = 1'b1;
          ch_inc  = !last_ch;
          cal_fin = last_ch;
        end
      end
      sacs_pkg::ST_OUT: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sacs_pkg::ST_IDLE;
      ch_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (ch_clr)      ch_r <= '0;
      else if (ch_inc) ch_r <= ch_r + sacs_pkg::CH_W'(1);
    end
  end

  // ------------------------------------------------------------------
  // Word capture
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      smp_r[0] <= in_chan.left_x;
      smp_r[1] <= in_chan.left_y;
      smp_r[2] <= in_chan.right_x;
      smp_r[3] <= in_chan.right_y;
      slot_r   <= slot_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_slot_r <= '0;
      was_cal_r    <= 1'b0;
      done_r       <= 1'b0;
    end else begin
      if (in_acc) begin
        write_slot_r <= slot_eff + SLOT_W'(1);
        // op restarts calibration before this word is processed
        was_cal_r    <= is_cal_r && !in_chan.op;
        done_r       <= 1'b0;
      end else if (cal_fin) begin
        done_r <= 1'b1;
      end
      if (win_clr) write_slot_r <= '0;
    end
  end

  // ------------------------------------------------------------------
  // Window memory: read in ST_READ, write back in ST_UPDATE. Channels use
  // distinct entries and one word is in flight, so a read never races a
  // pending write to the same entry.
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) win_mem[mem_addr] <= smp_r[ch_r];
    if (mem_re) win_rd_r <= win_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (mem_re) rd_vld_r <= win_vld_r[mem_addr];
      if (win_clr)     win_vld_r <= '0;
      else if (mem_we) win_vld_r[mem_addr] <= 1'b1;
    end
  end

  // Running sum: drop the oldest sample, add the new one
  logic [SUM_W-1:0] old_smp;
  logic [SUM_W-1:0] new_sum;
  assign old_smp = rd_vld_r ? SUM_W'(win_rd_r) : '0;
  assign new_sum = wsum_r[ch_r] - old_smp + SUM_W'(smp_r[ch_r]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sacs_pkg::NUM_CH; i++) wsum_r[i] <= '0;
    end else if (win_clr) begin
      for (int i = 0; i < sacs_pkg::NUM_CH; i++) wsum_r[i] <= '0;
    end else if (mem_we) begin
      wsum_r[ch_r] <= new_sum;
    end
  end

  // ------------------------------------------------------------------
  // Shared divider: (sum << 8) / w per channel, cal_sum / count at the end
  // ------------------------------------------------------------------
  always_comb begin
    div_req.start = div_start;
    if (div_sel_cal) begin
      div_req.nbits    = sacs_pkg::NB_W'(sacs_pkg::DIV_W);
      div_req.dividend = cal_sum_r[ch_r];
      div_req.divisor  = cal_ctr_r;
    end else begin
      div_req.nbits    = sacs_pkg::NB_W'(AVG_BITS);
      div_req.dividend = sacs_pkg::DIV_W'(new_sum) << sacs_pkg::FRAC_SH;
      div_req.divisor  = sacs_pkg::DVS_W'(w_eff);
    end
  end

  sacs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (avg_cap) avg_r[ch_r] <= div_rsp.quotient[sacs_pkg::AVG_W-1:0];
  end

  // ------------------------------------------------------------------
  // Scaling: one shared multiplier, then sign-magnitude shift and clamp
  // ------------------------------------------------------------------
  logic signed [sacs_pkg::AVG_W:0]    dev_s;
  logic signed [sacs_pkg::SMP_W:0]    gain_s;
  logic signed [sacs_pkg::PROD_W-1:0] prod_nxt;

  assign dev_s    = $signed({1'b0, avg_r[ch_r]}) - $signed({1'b0, offs_r[ch_r]});
  assign gain_s   = $signed({1'b0, gain_r});
  assign prod_nxt = dev_s * gain_s;

  always_ff @(posedge clk) begin
    if (mul_en) prod_r <= prod_nxt;
  end

  localparam int TMAG_W = sacs_pkg::PROD_W - sacs_pkg::GAIN_SH;
  localparam int V_W    = 16;

  logic                       prod_neg;
  logic [sacs_pkg::PROD_W-1:0] prod_mag;
  logic [TMAG_W-1:0]          tmag;
  logic signed [V_W-1:0]      ctr_s;
  logic signed [V_W-1:0]      tmag_s;
  logic signed [V_W-1:0]      v_sum;
  logic signed [V_W-1:0]      v_hi;
  logic signed [V_W-1:0]      v_lo;

  always_comb begin
    prod_neg = prod_r[sacs_pkg::PROD_W-1];
    prod_mag = prod_neg ? sacs_pkg::PROD_W'(-prod_r) : sacs_pkg::PROD_W'(prod_r);
    // truncate toward zero: shift the magnitude, reapply the sign
    tmag     = prod_mag[sacs_pkg::PROD_W-1:sacs_pkg::GAIN_SH];
    ctr_s    = $signed(V_W'(center_r));
    tmag_s   = $signed(V_W'(tmag));
    v_sum    = prod_neg ? ctr_s - tmag_s : ctr_s + tmag_s;
    v_hi     = (v_sum > $signed(V_W'(upper_r))) ? $signed(V_W'(upper_r)) : v_sum;
    // lower limit applied last so it wins when the limits cross
    v_lo     = (v_hi < $signed(V_W'(lower_r))) ? $signed(V_W'(lower_r)) : v_hi;
  end

  always_ff @(posedge clk) begin
    if (thr_cap) thr_r[ch_r] <= v_lo[sacs_pkg::SMP_W-1:0];
  end

  // ------------------------------------------------------------------
  // Calibration accumulate and offset update
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_ctr_r <= '0;
      is_cal_r  <= 1'b0;
      for (int i = 0; i < sacs_pkg::NUM_CH; i++) begin
        cal_sum_r[i] <= '0;
        offs_r[i]    <= '0;
      end
    end else begin
      if (in_acc && in_chan.op) begin
        cal_ctr_r <= '0;
        is_cal_r  <= 1'b0;
        for (int i = 0; i < sacs_pkg::NUM_CH; i++) cal_sum_r[i] <= '0;
      end else if (cal_acc) begin
        cal_ctr_r <= ctr_inc;
        for (int i = 0; i < sacs_pkg::NUM_CH; i++) begin
          cal_sum_r[i] <= cal_sum_r[i] + sacs_pkg::CSUM_W'(avg_r[i]);
        end
      end else if (off_cap) begin
        offs_r[ch_r] <= div_rsp.quotient[sacs_pkg::AVG_W-1:0];
        if (cal_fin) begin
          cal_ctr_r <= '0;
          is_cal_r  <= 1'b1;
          for (int i = 0; i < sacs_pkg::NUM_CH; i++) cal_sum_r[i] <= '0;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Output register: hold the result until taken
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_yaw_r        <= was_cal_r ? thr_r[0] : center_r;
      out_height_r     <= was_cal_r ? thr_r[1] : center_r;
      out_pitch_r      <= was_cal_r ? thr_r[3] : center_r;
      out_roll_r       <= was_cal_r ? thr_r[2] : center_r;
      out_calibrated_r <= was_cal_r;
      out_cal_done_r   <= done_r;
    end
  end

  assign in_chan.ready       = in_ready;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.yaw_out    = out_yaw_r;
  assign out_chan.height_out = out_height_r;
  assign out_chan.pitch_out  = out_pitch_r;
  assign out_chan.roll_out   = out_roll_r;
  assign out_chan.calibrated = out_calibrated_r;
  assign out_chan.cal_done   = out_cal_done_r;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_rmw_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> $past(mem_re) && mem_addr == $past(mem_addr))
    else $error("window write-back not paired with its read");

  a_done_not_cal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_cal_done_r && out_calibrated_r))
    else $error("cal_done reported on a calibrated word");

  a_cal_set_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(is_cal_r) |-> $past(state_r) == sacs_pkg::ST_CAL_DIV)
    else $error("calibrated flag set outside the offset update");

endmodule

`default_nettype wire

// File: design/sacs_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, shared by the block.
// Depends on sacs_pkg for the request/response structs and widths.
`default_nettype none

module sacs_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sacs_pkg::div_req_t req,
  output sacs_pkg::div_rsp_t      rsp
);

  logic [sacs_pkg::DIV_W-1:0] q_r;
  logic [sacs_pkg::DVS_W-1:0] rem_r;
  logic [sacs_pkg::DVS_W-1:0] dvs_r;
  logic [sacs_pkg::NB_W-1:0]  cnt_r;
  logic                       busy_r;
  logic                       done_r;

  logic [sacs_pkg::NB_W-1:0]  shamt;
  logic [sacs_pkg::DVS_W:0]   rem_sh;
  logic                       ge;
  logic [sacs_pkg::DVS_W:0]   rem_nxt;

  // Left-align the dividend so only the requested quotient bits are iterated
  assign shamt   = sacs_pkg::NB_W'(sacs_pkg::DIV_W) - req.nbits;
  assign rem_sh  = {rem_r, q_r[sacs_pkg::DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_nxt = ge ? rem_sh - {1'b0, dvs_r} : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - sacs_pkg::NB_W'(1);
        if (cnt_r == sacs_pkg::NB_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= req.dividend << shamt;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[sacs_pkg::DIV_W-2:0], ge};
      rem_r <= rem_nxt[sacs_pkg::DVS_W-1:0];
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule

`default_nettype wire

// File: dv/stick_average_calibrate_scale_top_tb.sv
// Self-checking testbench for stick_average_calibrate_scale_top.
// Needs sacs_pkg, sacs_in_if, sacs_out_if and the design sources; reads no files.
// Scoreboard checks every result word against an internal predictor.
`timescale 1ns / 100ps

module stick_average_calibrate_scale_top_tb;

  localparam int          MAX_WIN      = 16;
  localparam int unsigned RANDOM_WORDS = 400;
  localparam int unsigned SETTLE       = 6;       // idle cycles before register writes
  localparam int unsigned TAIL         = 300;     // settle time for the final drain
  localparam int unsigned LIMIT        = 1000000; // cycle budget for the whole run

  // One input word and one result word, field by field.
  typedef struct packed {
    logic                       op;
    logic [sacs_pkg::SMP_W-1:0] left_x;
    logic [sacs_pkg::SMP_W-1:0] left_y;
    logic [sacs_pkg::SMP_W-1:0] right_x;
    logic [sacs_pkg::SMP_W-1:0] right_y;
  } stick_word_t;

  typedef struct packed {
    logic [sacs_pkg::SMP_W-1:0] yaw;
    logic [sacs_pkg::SMP_W-1:0] height;
    logic [sacs_pkg::SMP_W-1:0] pitch;
    logic [sacs_pkg::SMP_W-1:0] roll;
    logic                       calibrated;
    logic                       cal_done;
  } throttle_word_t;

  // Op bit meanings.
  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_RECAL   = 1'b1;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            cfg_we    = 1'b0;
  logic [sacs_pkg::CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [sacs_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  sacs_in_if  in_chan ();
  sacs_out_if out_chan ();

  stick_average_calibrate_scale_top #(
    .MAX_WINDOW (MAX_WIN)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the registers and of the filter and
  // calibration state, updated on every accepted input word and register write.
  // ---------------------------------------------------------------------------
  logic [sacs_pkg::WLEN_W-1:0] win_len_q;
  logic [sacs_pkg::CNT_W-1:0]  cal_need_q;
  logic [sacs_pkg::SMP_W-1:0]  gain_q;
  logic [sacs_pkg::SMP_W-1:0]  center_q;
  logic [sacs_pkg::SMP_W-1:0]  upper_q;
  logic [sacs_pkg::SMP_W-1:0]  lower_q;

  logic [sacs_pkg::SMP_W-1:0]  win_mem [sacs_pkg::NUM_CH][MAX_WIN];
  int unsigned                 slot_q;
  logic [15:0]                 win_sum [sacs_pkg::NUM_CH];
  logic [sacs_pkg::CNT_W-1:0]  cal_cnt_q;
  logic [sacs_pkg::CSUM_W-1:0] cal_acc [sacs_pkg::NUM_CH];
  logic [sacs_pkg::AVG_W-1:0]  offset_q [sacs_pkg::NUM_CH];
  logic                        cal_valid_q;

  stick_word_t    stick_q [$];     // words waiting to be driven
  throttle_word_t throttle_q [$];  // predicted results, oldest first

  int unsigned n_words_in   = 0;
  int unsigned n_checked    = 0;
  int unsigned n_cal_done   = 0;
  int unsigned n_scaled     = 0;
  int unsigned n_cfg_writes = 0;
  int unsigned mismatches   = 0;
  int unsigned cycles       = 0;
  bit          calm         = 1'b0;  // no gaps and no stalls while set

  function automatic void clear_window();
    for (int c = 0; c < sacs_pkg::NUM_CH; c++) begin
      win_sum[c] = '0;
      for (int s = 0; s < MAX_WIN; s++) win_mem[c][s] = '0;
    end
    slot_q = 0;
  endfunction

  function automatic void restart_cal();
    cal_cnt_q = '0;
    for (int c = 0; c < sacs_pkg::NUM_CH; c++) cal_acc[c] = '0;
    cal_valid_q = 1'b0;
  endfunction

  function automatic void reset_model();
    win_len_q  = sacs_pkg::RST_WINDOW_LEN;
    cal_need_q = sacs_pkg::RST_CAL_COUNT;
    gain_q     = sacs_pkg::RST_GAIN;
    center_q   = sacs_pkg::RST_CENTER_VALUE;
    upper_q    = sacs_pkg::RST_UPPER_LIMIT;
    lower_q    = sacs_pkg::RST_LOWER_LIMIT;
    clear_window();
    restart_cal();
    for (int c = 0; c < sacs_pkg::NUM_CH; c++) offset_q[c] = '0;
  endfunction

  function automatic void apply_reg(logic [sacs_pkg::CFG_IDX_W-1:0] idx,
                                    logic [sacs_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      sacs_pkg::REG_WINDOW_LEN: begin
        win_len_q = val[sacs_pkg::WLEN_W-1:0];
        clear_window();   // writing the length flushes the window
      end
      sacs_pkg::REG_CAL_COUNT:    cal_need_q = val[sacs_pkg::CNT_W-1:0];
      sacs_pkg::REG_GAIN:         gain_q     = val[sacs_pkg::SMP_W-1:0];
      sacs_pkg::REG_CENTER_VALUE: center_q   = val[sacs_pkg::SMP_W-1:0];
      sacs_pkg::REG_UPPER_LIMIT:  upper_q    = val[sacs_pkg::SMP_W-1:0];
      sacs_pkg::REG_LOWER_LIMIT:  lower_q    = val[sacs_pkg::SMP_W-1:0];
      default: ;
    endcase
  endfunction

  // center + trunc-toward-zero((avg - offset) * gain / 2^20), upper clamp first,
  // lower clamp last so a crossed pair resolves to the lower limit.
  function automatic logic [sacs_pkg::SMP_W-1:0] scale_axis(
      logic [sacs_pkg::CSUM_W-1:0] avg, logic [sacs_pkg::AVG_W-1:0] off);
    longint dev, prod, mag, delta, val, hi, lo;
    dev   = avg;
    dev   = dev - longint'(off);
    prod  = gain_q;
    prod  = prod * dev;
    mag   = (prod < 0) ? -prod : prod;
    delta = mag >> sacs_pkg::GAIN_SH;
    if (prod < 0) delta = -delta;
    val = center_q;
    val = val + delta;
    hi  = upper_q;
    lo  = lower_q;
    if (val > hi) val = hi;
    if (val < lo) val = lo;
    return val[sacs_pkg::SMP_W-1:0];
  endfunction

  // Advance the filter and calibration by one word; return the expected result.
  function automatic throttle_word_t predict_throttles(stick_word_t word);
    throttle_word_t              res;
    int unsigned                 wl;
    logic [sacs_pkg::SMP_W-1:0]  smp [sacs_pkg::NUM_CH];
    logic [sacs_pkg::CSUM_W-1:0] avg [sacs_pkg::NUM_CH];
    logic [sacs_pkg::SMP_W-1:0]  thr [sacs_pkg::NUM_CH];
    logic                        was_cal;
    logic                        done;
    logic [sacs_pkg::CNT_W-1:0]  need;
    wl = (win_len_q == 0 || win_len_q > MAX_WIN) ? MAX_WIN : win_len_q;
    if (slot_q >= wl) slot_q = 0;
    if (word.op == OP_RECAL) restart_cal();
    smp[0] = word.left_x;
    smp[1] = word.left_y;
    smp[2] = word.right_x;
    smp[3] = word.right_y;
    for (int c = 0; c < sacs_pkg::NUM_CH; c++) begin
      win_sum[c] = win_sum[c] - win_mem[c][slot_q] + 16'(smp[c]);
      win_mem[c][slot_q] = smp[c];
      avg[c] = ({16'd0, win_sum[c]} << sacs_pkg::FRAC_SH) / wl;
    end
    slot_q++;

    was_cal = cal_valid_q;
    for (int c = 0; c < sacs_pkg::NUM_CH; c++)
      thr[c] = was_cal ? scale_axis(avg[c], offset_q[c]) : center_q;

    done = 1'b0;
    if (!was_cal) begin
      need = (cal_need_q == 0) ? sacs_pkg::CNT_W'(1) : cal_need_q;
      for (int c = 0; c < sacs_pkg::NUM_CH; c++) cal_acc[c] = cal_acc[c] + avg[c];
      cal_cnt_q = cal_cnt_q + 1'b1;
      // A count lowered mid-run finishes here and divides by what was summed.
      if (cal_cnt_q >= need) begin
        for (int c = 0; c < sacs_pkg::NUM_CH; c++)
          offset_q[c] = sacs_pkg::AVG_W'(cal_acc[c] / {21'd0, cal_cnt_q});
        restart_cal();
        cal_valid_q = 1'b1;
        done = 1'b1;
      end
    end

    res.yaw        = thr[0];
    res.height     = thr[1];
    res.pitch      = thr[3];
    res.roll       = thr[2];
    res.calibrated = was_cal;
    res.cal_done   = done;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 100);
  endfunction

  function automatic stick_word_t stick(logic op, int unsigned lx, int unsigned ly,
                                        int unsigned rx, int unsigned ry);
    stick_word_t w;
    w.op      = op;
    w.left_x  = sacs_pkg::SMP_W'(lx);
    w.left_y  = sacs_pkg::SMP_W'(ly);
    w.right_x = sacs_pkg::SMP_W'(rx);
    w.right_y = sacs_pkg::SMP_W'(ry);
    return w;
  endfunction

  // Mostly uniform counts, with rails and a band around mid-scale mixed in.
  function automatic logic [sacs_pkg::SMP_W-1:0] random_sample();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return '0;
      1:       return '1;
      2, 3:    return sacs_pkg::SMP_W'($urandom_range(1748, 2348));
      default: return sacs_pkg::SMP_W'($urandom);
    endcase
  endfunction

  function automatic stick_word_t random_stick(logic op);
    return stick(op, random_sample(), random_sample(), random_sample(), random_sample());
  endfunction

  // Write one register at a falling edge and mirror it into the predictor.
  task automatic write_reg(logic [sacs_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= sacs_pkg::CFG_DATA_W'(val);
    apply_reg(idx, sacs_pkg::CFG_DATA_W'(val));
    n_cfg_writes++;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Hold until every queued word went in and every predicted result came out.
  task automatic wait_drained(int unsigned settle);
    while (stick_q.size() != 0 || in_chan.valid || throttle_q.size() != 0)
      @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // New register settings for a random phase; extremes come up regularly.
  task automatic shuffle_settings();
    int unsigned r, mid, val;
    if ($urandom_range(0, 9) < 6) begin
      r = $urandom_range(0, 9);
      if (r == 0)      val = 0;
      else if (r == 1) val = $urandom_range(MAX_WIN + 1, 31);   // too long, acts as max
      else if (r == 2) val = MAX_WIN;
      else             val = $urandom_range(1, MAX_WIN - 1);
      write_reg(sacs_pkg::REG_WINDOW_LEN, val);
    end
    if ($urandom_range(0, 9) < 6) begin
      r = $urandom_range(0, 9);
      if (r == 0)      val = 0;
      else if (r == 1) val = 1;
      else if (r == 9) val = $urandom_range(13, 40);
      else             val = $urandom_range(2, 12);
      write_reg(sacs_pkg::REG_CAL_COUNT, val);
    end
    if ($urandom_range(0, 9) < 7) begin
      r = $urandom_range(0, 9);
      val = (r == 0) ? 0 : (r == 1) ? 4095 : $urandom_range(0, 4095);
      write_reg(sacs_pkg::REG_GAIN, val);
    end
    if ($urandom_range(0, 9) < 6) begin
      mid = $urandom_range(0, 4095);
      write_reg(sacs_pkg::REG_CENTER_VALUE, mid);
      r = $urandom_range(0, 19);
      if (r < 3) begin
        // random limits, which may cross
        write_reg(sacs_pkg::REG_UPPER_LIMIT, $urandom_range(0, 4095));
        write_reg(sacs_pkg::REG_LOWER_LIMIT, $urandom_range(0, 4095));
      end else if (r < 5) begin
        write_reg(sacs_pkg::REG_UPPER_LIMIT, 4095);
        write_reg(sacs_pkg::REG_LOWER_LIMIT, 0);
      end else begin
        write_reg(sacs_pkg::REG_UPPER_LIMIT, $urandom_range(mid, 4095));
        write_reg(sacs_pkg::REG_LOWER_LIMIT, $urandom_range(0, mid));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input driver. Acceptance is sampled at the rising edge; the falling edge
  // then predicts the accepted word and presents the next one.
  // ---------------------------------------------------------------------------
  logic        in_took  = 1'b0;
  stick_word_t word_now = '0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    in_took <= rst_n && in_chan.valid && in_chan.ready;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_took) begin
        throttle_q.push_back(predict_throttles(word_now));
        n_words_in++;
      end
      if (in_chan.valid && !in_took) begin
        // hold the word until the block takes it
      end else if (gap_left > 0) begin
        gap_left--;
        in_chan.valid <= 1'b0;
      end else if (stick_q.size() > 0) begin
        word_now = stick_q.pop_front();
        in_chan.op      <= word_now.op;
        in_chan.left_x  <= word_now.left_x;
        in_chan.left_y  <= word_now.left_y;
        in_chan.right_x <= word_now.right_x;
        in_chan.right_y <= word_now.right_y;
        in_chan.valid   <= 1'b1;
        gap_left = calm ? 0 : pick_gap();
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: random backpressure at the falling edge, checks at the
  // rising edge against the oldest prediction.
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
      if (!calm && $urandom_range(0, 7) == 0) stall_left = pick_gap();
    end
  end

  function automatic void check_field(string name, logic [sacs_pkg::SMP_W-1:0] want,
                                      logic [sacs_pkg::SMP_W-1:0] seen);
    if (seen !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, seen);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    throttle_word_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (throttle_q.size() == 0) begin
        $error("result word with no prediction pending");
        mismatches++;
      end else begin
        want = throttle_q.pop_front();
        check_field("yaw_out",    want.yaw,        out_chan.yaw_out);
        check_field("height_out", want.height,     out_chan.height_out);
        check_field("pitch_out",  want.pitch,      out_chan.pitch_out);
        check_field("roll_out",   want.roll,       out_chan.roll_out);
        check_field("calibrated", want.calibrated, out_chan.calibrated);
        check_field("cal_done",   want.cal_done,   out_chan.cal_done);
        n_checked++;
        if (want.cal_done)   n_cal_done++;
        if (want.calibrated) n_scaled++;
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("stick_average_calibrate_scale_top_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned phase, len, n_random;
    logic        op;

    in_chan.valid   = 1'b0;
    in_chan.op      = 1'b0;
    in_chan.left_x  = '0;
    in_chan.left_y  = '0;
    in_chan.right_x = '0;
    in_chan.right_y = '0;
    out_chan.ready  = 1'b0;
    reset_model();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: long calibration, so these words all report center.
    stick_q.push_back(stick(OP_SAMPLE, 0, 0, 0, 0));
    stick_q.push_back(stick(OP_SAMPLE, 4095, 4095, 4095, 4095));
    stick_q.push_back(stick(OP_SAMPLE, 'hAAA, 'h555, 'hAAA, 'h555));
    stick_q.push_back(stick(OP_SAMPLE, 'h555, 'hAAA, 'h555, 'hAAA));
    wait_drained(SETTLE);

    // Drop the count below what was already summed: the next word finishes
    // calibration and divides by five. Then drive rails against the offsets.
    write_reg(sacs_pkg::REG_CAL_COUNT, 2);
    stick_q.push_back(stick(OP_SAMPLE, 4095, 0, 4095, 0));
    stick_q.push_back(stick(OP_SAMPLE, 4095, 4095, 4095, 4095));
    stick_q.push_back(stick(OP_SAMPLE, 0, 0, 0, 0));
    stick_q.push_back(stick(OP_SAMPLE, 0, 0, 0, 0));
    wait_drained(SETTLE);

    // One-sample window, full gain, full-range limits; restart calibration.
    write_reg(sacs_pkg::REG_WINDOW_LEN, 1);
    write_reg(sacs_pkg::REG_GAIN, 4095);
    write_reg(sacs_pkg::REG_CENTER_VALUE, 0);
    write_reg(sacs_pkg::REG_UPPER_LIMIT, 4095);
    write_reg(sacs_pkg::REG_LOWER_LIMIT, 0);
    stick_q.push_back(stick(OP_RECAL, 2048, 2048, 2048, 2048));
    stick_q.push_back(stick(OP_SAMPLE, 2048, 2048, 2048, 2048));
    stick_q.push_back(stick(OP_SAMPLE, 4095, 0, 4095, 0));
    stick_q.push_back(stick(OP_SAMPLE, 0, 4095, 0, 4095));
    wait_drained(SETTLE);

    // Oversized window, zero count (acts as one), zero gain, crossed limits.
    write_reg(sacs_pkg::REG_WINDOW_LEN, 31);
    write_reg(sacs_pkg::REG_CAL_COUNT, 0);
    write_reg(sacs_pkg::REG_GAIN, 0);
    write_reg(sacs_pkg::REG_CENTER_VALUE, 2000);
    write_reg(sacs_pkg::REG_UPPER_LIMIT, 1000);
    write_reg(sacs_pkg::REG_LOWER_LIMIT, 3000);
    stick_q.push_back(random_stick(OP_RECAL));
    stick_q.push_back(random_stick(OP_SAMPLE));
    stick_q.push_back(random_stick(OP_SAMPLE));
    wait_drained(SETTLE);

    // Window length zero, a count of 1024, unit gain: small deviations must
    // truncate toward zero. Lower the count part way to finish early.
    write_reg(sacs_pkg::REG_WINDOW_LEN, 0);
    write_reg(sacs_pkg::REG_CAL_COUNT, 1024);
    write_reg(sacs_pkg::REG_GAIN, 1);
    write_reg(sacs_pkg::REG_CENTER_VALUE, 2048);
    write_reg(sacs_pkg::REG_UPPER_LIMIT, 4095);
    write_reg(sacs_pkg::REG_LOWER_LIMIT, 0);
    stick_q.push_back(stick(OP_RECAL, 1, 4094, 2047, 2049));
    stick_q.push_back(stick(OP_SAMPLE, 4095, 0, 100, 3000));
    stick_q.push_back(stick(OP_SAMPLE, 7, 4088, 2000, 2100));
    stick_q.push_back(stick(OP_SAMPLE, 0, 4095, 4095, 0));
    wait_drained(SETTLE);
    write_reg(sacs_pkg::REG_CAL_COUNT, 3);
    stick_q.push_back(stick(OP_SAMPLE, 2000, 2001, 1999, 2002));
    stick_q.push_back(stick(OP_SAMPLE, 1, 4094, 2047, 2049));
    wait_drained(SETTLE);

    // Random phases: mostly a restart followed by samples, with a stray
    // restart now and then. Every fourth phase runs without gaps or stalls.
    phase    = 0;
    n_random = 0;
    while (n_random < RANDOM_WORDS) begin
      calm = (phase % 4 == 3);
      shuffle_settings();
      len = $urandom_range(30, 70);
      for (int k = 0; k < len; k++) begin
        op = (k == 0) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 39) == 0);
        stick_q.push_back(random_stick(op));
      end
      n_random += len;
      wait_drained(SETTLE);
      phase++;
    end

    calm = 1'b0;
    wait_drained(TAIL);

    $display("Drove %0d stick words over %0d register writes; checked %0d results",
             n_words_in, n_cfg_writes, n_checked);
    $display("  %0d scaled throttle words, %0d calibrations completed, %0d mismatches",
             n_scaled, n_cal_done, mismatches);
    if (mismatches == 0 && throttle_q.size() == 0) begin
      $display("stick_average_calibrate_scale_top_tb: PASS");
    end else begin
      $display("stick_average_calibrate_scale_top_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
design/sacs_pkg.sv
design/sacs_in_if.sv
design/sacs_out_if.sv
design/sacs_div.sv
design/stick_average_calibrate_scale_top.sv
dv/stick_average_calibrate_scale_top_tb.sv
